// File: rtl/keyed_station_inventory_table_defines.svh
// Assertion macros shared by the keyed station inventory table.
// Depends on nothing; included by the top level.
`ifndef KEYED_STATION_INVENTORY_TABLE_DEFINES_SVH
`define KEYED_STATION_INVENTORY_TABLE_DEFINES_SVH

// Same-cycle implication under a synchronous reset.
`define KSIT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a synchronous reset.
`define KSIT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ksit_pkg.sv
// Package of the keyed station inventory table: codes, sizes and the
// command and status structs between controller and datapath. No dependencies.
package ksit_pkg;

   localparam int MAX_STATIONS_DEF = 16;
   localparam int MAX_ITEMS_DEF    = 16;
   localparam int RESULT_CAP       = 16;

   localparam logic [3:0] OP_CLEAR   = 4'd0;
   localparam logic [3:0] OP_REG     = 4'd1;
   localparam logic [3:0] OP_GET     = 4'd2;
   localparam logic [3:0] OP_ITER    = 4'd3;
   localparam logic [3:0] OP_COUNT   = 4'd4;
   localparam logic [3:0] OP_INV_GET = 4'd5;
   localparam logic [3:0] OP_INV_ADD = 4'd6;
   localparam logic [3:0] OP_INV_REM = 4'd7;
   localparam logic [3:0] OP_INV_LST = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVARG   = 3'd1;
   localparam logic [2:0] ST_INVDATA  = 3'd2;
   localparam logic [2:0] ST_DUP      = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_INSUFF   = 3'd6;
   localparam logic [2:0] ST_FULL     = 3'd7;

   localparam logic [2:0] IX_HOLD   = 3'd0;
   localparam logic [2:0] IX_ZERO   = 3'd1;
   localparam logic [2:0] IX_INC    = 3'd2;
   localparam logic [2:0] IX_DEC    = 3'd3;
   localparam logic [2:0] IX_ICOUNT = 3'd4;

   localparam logic [1:0] RD_IDX  = 2'd0;
   localparam logic [1:0] RD_PREV = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   localparam logic [1:0] WS_COPY = 2'd0;
   localparam logic [1:0] WS_UPD  = 2'd1;
   localparam logic [1:0] WS_NEW  = 2'd2;

   localparam logic [1:0] K_STATUS  = 2'd0;
   localparam logic [1:0] K_STATION = 2'd1;
   localparam logic [1:0] K_ITEM    = 2'd2;

   localparam logic [1:0] T_NONE     = 2'd0;
   localparam logic [1:0] T_STATIONS = 2'd1;
   localparam logic [1:0] T_ITEMS    = 2'd2;

   localparam logic [1:0] Q_MEM  = 2'd0;
   localparam logic [1:0] Q_UPD  = 2'd1;
   localparam logic [1:0] Q_AMT  = 2'd2;
   localparam logic [1:0] Q_ZERO = 2'd3;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic [2:0] idx_op;
      logic       set_pos;
      logic       found_val;
      logic       set_ifound;
      logic       ifound_val;
      logic       set_ipos;
      logic       s_insert;
      logic       mem_rd;
      logic [1:0] rd_sel;
      logic       mem_wr;
      logic [1:0] wr_sel;
      logic       items_inc;
      logic       items_dec;
      logic       emit;
      logic [1:0] kind;
      logic [1:0] tot_sel;
      logic [1:0] qsel;
      logic [2:0] rstatus;
      logic       last;
   } ksit_cmd_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic       sk_zero;
      logic       bk_zero;
      logic       rk_zero;
      logic       amt_pos;
      logic       s_empty;
      logic       s_full;
      logic       s_end;
      logic       s_eq;
      logic       s_gt;
      logic       found;
      logic       s_last;
      logic       i_end;
      logic       i_eq;
      logic       i_gt;
      logic       ifound;
      logic       i_full;
      logic       add_ovf;
      logic       rem_short;
      logic       rem_zero;
      logic       idx_gt_ipos;
      logic       dn_more;
      logic       l_none;
      logic       l_last;
   } ksit_stat_type;

endpackage

// File: rtl/ksit_ctrl.sv
// Controller state machine of the keyed station inventory table.
// Depends on ksit_pkg; drives ksit_dpath through command and status structs.
module ksit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ksit_pkg::ksit_stat_type stat,
   output ksit_pkg::ksit_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_SSRCH  = 4'd2;
   localparam logic [3:0] S_SDONE  = 4'd3;
   localparam logic [3:0] S_ITER   = 4'd4;
   localparam logic [3:0] S_IRD    = 4'd5;
   localparam logic [3:0] S_ICK    = 4'd6;
   localparam logic [3:0] S_IDONE  = 4'd7;
   localparam logic [3:0] S_UPRD   = 4'd8;
   localparam logic [3:0] S_UPWR   = 4'd9;
   localparam logic [3:0] S_DNRD   = 4'd10;
   localparam logic [3:0] S_DNWR   = 4'd11;
   localparam logic [3:0] S_LSTART = 4'd12;
   localparam logic [3:0] S_LRD    = 4'd13;
   localparam logic [3:0] S_LEM    = 4'd14;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.idx_op = ksit_pkg::IX_HOLD;
      cmd.kind = ksit_pkg::K_STATUS;
      cmd.tot_sel = ksit_pkg::T_NONE;
      cmd.rstatus = ksit_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cmd.idx_op = ksit_pkg::IX_ZERO;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            unique case (stat.opcode)
               ksit_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               ksit_pkg::OP_REG: begin
                  if (stat.sk_zero || stat.bk_zero) begin
                     cmd.rstatus = ksit_pkg::ST_INVDATA;
                  end else begin
                     cmd.emit = 1'b0;
                     state_in = S_SSRCH;
                  end
               end
               ksit_pkg::OP_GET: begin
                  cmd.emit = 1'b0;
                  state_in = S_SSRCH;
               end
               ksit_pkg::OP_ITER: begin
                  if (!stat.s_empty) begin
                     cmd.emit = 1'b0;
                     state_in = S_ITER;
                  end
               end
               ksit_pkg::OP_COUNT: begin
                  cmd.tot_sel = ksit_pkg::T_STATIONS;
               end
               ksit_pkg::OP_INV_GET, ksit_pkg::OP_INV_ADD, ksit_pkg::OP_INV_REM: begin
                  priority if (stat.sk_zero || stat.rk_zero) begin
                     cmd.rstatus = ksit_pkg::ST_INVARG;
                  end else if (stat.opcode != ksit_pkg::OP_INV_GET && !stat.amt_pos) begin
                     cmd.rstatus = ksit_pkg::ST_INVDATA;
                  end else begin
                     cmd.emit = 1'b0;
                     state_in = S_SSRCH;
                  end
               end
               ksit_pkg::OP_INV_LST: begin
                  if (stat.sk_zero) begin
                     cmd.rstatus = ksit_pkg::ST_INVARG;
                  end else begin
                     cmd.emit = 1'b0;
                     state_in = S_SSRCH;
                  end
               end
               default: begin
                  cmd.rstatus = ksit_pkg::ST_INVARG;
               end
            endcase
         end
         S_SSRCH: begin
            priority if (stat.s_end || stat.s_gt) begin
               cmd.set_pos = 1'b1;
               state_in = S_SDONE;
            end else if (stat.s_eq) begin
               cmd.set_pos = 1'b1;
               cmd.found_val = 1'b1;
               state_in = S_SDONE;
            end else begin
               cmd.idx_op = ksit_pkg::IX_INC;
            end
         end
         S_SDONE: begin
            state_in = S_IDLE;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            priority if (stat.opcode == ksit_pkg::OP_REG) begin
               priority if (stat.found) begin
                  cmd.rstatus = ksit_pkg::ST_DUP;
               end else if (stat.s_full) begin
                  cmd.rstatus = ksit_pkg::ST_FULL;
               end else begin
                  cmd.s_insert = 1'b1;
               end
            end else if (!stat.found) begin
               cmd.rstatus = ksit_pkg::ST_NOTFOUND;
            end else if (stat.opcode == ksit_pkg::OP_GET) begin
               cmd.kind = ksit_pkg::K_STATION;
            end else begin
               cmd.emit = 1'b0;
               cmd.idx_op = ksit_pkg::IX_ZERO;
               state_in = (stat.opcode == ksit_pkg::OP_INV_LST) ? S_LSTART : S_IRD;
            end
         end
         S_ITER: begin
            cmd.emit = 1'b1;
            cmd.kind = ksit_pkg::K_STATION;
            cmd.tot_sel = ksit_pkg::T_STATIONS;
            cmd.last = stat.s_last;
            if (stat.s_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_op = ksit_pkg::IX_INC;
            end
         end
         S_IRD: begin
            if (stat.i_end) begin
               cmd.set_ifound = 1'b1;
               state_in = S_IDONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = ksit_pkg::RD_IDX;
               state_in = S_ICK;
            end
         end
         S_ICK: begin
            priority if (stat.i_eq) begin
               cmd.set_ifound = 1'b1;
               cmd.ifound_val = 1'b1;
               state_in = S_IDONE;
            end else if (stat.i_gt) begin
               cmd.set_ifound = 1'b1;
               state_in = S_IDONE;
            end else begin
               cmd.idx_op = ksit_pkg::IX_INC;
               state_in = S_IRD;
            end
         end
         S_IDONE: begin
            state_in = S_IDLE;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.kind = ksit_pkg::K_ITEM;
            priority if (stat.opcode == ksit_pkg::OP_INV_GET) begin
               cmd.qsel = ksit_pkg::Q_MEM;
               if (!stat.ifound) begin
                  cmd.kind = ksit_pkg::K_STATUS;
                  cmd.rstatus = ksit_pkg::ST_NOTFOUND;
               end
            end else if (stat.opcode == ksit_pkg::OP_INV_ADD) begin
               priority if (stat.ifound && stat.add_ovf) begin
                  cmd.kind = ksit_pkg::K_STATUS;
                  cmd.rstatus = ksit_pkg::ST_OVERFLOW;
               end else if (stat.ifound) begin
                  cmd.mem_wr = 1'b1;
                  cmd.wr_sel = ksit_pkg::WS_UPD;
                  cmd.qsel = ksit_pkg::Q_UPD;
               end else if (stat.i_full) begin
                  cmd.kind = ksit_pkg::K_STATUS;
                  cmd.rstatus = ksit_pkg::ST_FULL;
               end else begin
                  cmd.emit = 1'b0;
                  cmd.set_ipos = 1'b1;
                  cmd.idx_op = ksit_pkg::IX_ICOUNT;
                  state_in = S_UPRD;
               end
            end else begin
               priority if (!stat.ifound || stat.rem_short) begin
                  cmd.kind = ksit_pkg::K_STATUS;
                  cmd.rstatus = ksit_pkg::ST_INSUFF;
               end else if (stat.rem_zero) begin
                  cmd.emit = 1'b0;
                  state_in = S_DNRD;
               end else begin
                  cmd.mem_wr = 1'b1;
                  cmd.wr_sel = ksit_pkg::WS_UPD;
                  cmd.qsel = ksit_pkg::Q_UPD;
               end
            end
         end
         S_UPRD: begin
            if (stat.idx_gt_ipos) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = ksit_pkg::RD_PREV;
               state_in = S_UPWR;
            end else begin
               cmd.mem_wr = 1'b1;
               cmd.wr_sel = ksit_pkg::WS_NEW;
               cmd.items_inc = 1'b1;
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.kind = ksit_pkg::K_ITEM;
               cmd.qsel = ksit_pkg::Q_AMT;
               state_in = S_IDLE;
            end
         end
         S_UPWR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = ksit_pkg::WS_COPY;
            cmd.idx_op = ksit_pkg::IX_DEC;
            state_in = S_UPRD;
         end
         S_DNRD: begin
            if (stat.dn_more) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = ksit_pkg::RD_NEXT;
               state_in = S_DNWR;
            end else begin
               cmd.items_dec = 1'b1;
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.kind = ksit_pkg::K_ITEM;
               cmd.qsel = ksit_pkg::Q_ZERO;
               state_in = S_IDLE;
            end
         end
         S_DNWR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = ksit_pkg::WS_COPY;
            cmd.idx_op = ksit_pkg::IX_INC;
            state_in = S_DNRD;
         end
         S_LSTART: begin
            if (stat.l_none) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.tot_sel = ksit_pkg::T_ITEMS;
               state_in = S_IDLE;
            end else begin
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = ksit_pkg::RD_IDX;
            state_in = S_LEM;
         end
         S_LEM: begin
            cmd.emit = 1'b1;
            cmd.kind = ksit_pkg::K_ITEM;
            cmd.qsel = ksit_pkg::Q_MEM;
            cmd.tot_sel = ksit_pkg::T_ITEMS;
            cmd.last = stat.l_last;
            if (stat.l_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_op = ksit_pkg::IX_INC;
               state_in = S_LRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ksit_dpath.sv
// Datapath of the keyed station inventory table: request and station registers,
// inventory memory, index counters and result registers. Depends on ksit_pkg.
module ksit_dpath #(
   parameter int MAX_STATIONS          = ksit_pkg::MAX_STATIONS_DEF,
   parameter int MAX_ITEMS_PER_STATION = ksit_pkg::MAX_ITEMS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [3:0]              req_opcode,
   input  logic [63:0]             req_station_key,
   input  logic [63:0]             req_body_key,
   input  logic [63:0]             req_frame_key,
   input  logic [63:0]             req_resource_key,
   input  logic signed [63:0]      req_amount,
   input  logic [4:0]              req_max_items,
   input  ksit_pkg::ksit_cmd_type  cmd,
   output ksit_pkg::ksit_stat_type stat,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [63:0]             rsp_out_station,
   output logic [63:0]             rsp_out_body,
   output logic [63:0]             rsp_out_frame,
   output logic [63:0]             rsp_out_resource,
   output logic [62:0]             rsp_quantity,
   output logic [4:0]              rsp_total,
   output logic                    rsp_item_valid,
   output logic                    rsp_last
);

   localparam int SW  = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int IW  = (MAX_ITEMS_PER_STATION > 1) ? $clog2(MAX_ITEMS_PER_STATION) : 1;
   localparam int SCW = $clog2(MAX_STATIONS + 1);
   localparam int ICW = $clog2(MAX_ITEMS_PER_STATION + 1);
   localparam int IXW = (SCW > ICW) ? SCW : ICW;
   localparam int SD  = 1 << SW;
   localparam int MD  = 1 << (SW + IW);

   logic [3:0]      op_ff;
   logic [63:0]     sk_ff, bk_ff, fk_ff, rk_ff;
   logic [62:0]     amt_ff;
   logic            amt_neg_ff;
   logic [4:0]      maxi_ff;

   logic [63:0]     sid_ff [SD];
   logic [63:0]     sbd_ff [SD];
   logic [63:0]     sfr_ff [SD];
   logic [SW-1:0]   smap_ff [SD];
   logic [SCW-1:0]  used_ff;
   logic [ICW-1:0]  icnt_ff [SD];

   logic [63:0]     mid_mem [MD];
   logic [62:0]     mq_mem [MD];
   logic [63:0]     mem_id_ff;
   logic [62:0]     mem_q_ff;

   logic [IXW-1:0]  idx_ff, idx_in, pos_ff, ipos_ff;
   logic            found_ff, ifound_ff;

   logic [SW-1:0]   sx, slot;
   logic [ICW-1:0]  icnt;
   logic [IXW-1:0]  ridx;
   logic [63:0]     sum64;
   logic [62:0]     diff, qupd, qout, wq;
   logic [63:0]     wid;
   logic [31:0]     u32, n_iter, c32, m32, n_list, i32;

   assign sx   = idx_ff[SW-1:0];
   assign slot = smap_ff[pos_ff[SW-1:0]];
   assign icnt = icnt_ff[slot];

   assign sum64 = {1'b0, mem_q_ff} + {1'b0, amt_ff};
   assign diff  = mem_q_ff - amt_ff;
   assign qupd  = (op_ff == ksit_pkg::OP_INV_ADD) ? sum64[62:0] : diff;

   assign u32    = 32'(used_ff);
   assign n_iter = (u32 > 32'(ksit_pkg::RESULT_CAP)) ? 32'(ksit_pkg::RESULT_CAP) : u32;
   assign c32    = 32'(icnt);
   assign m32    = (c32 > 32'(maxi_ff)) ? 32'(maxi_ff) : c32;
   assign n_list = (m32 > 32'(ksit_pkg::RESULT_CAP)) ? 32'(ksit_pkg::RESULT_CAP) : m32;
   assign i32    = 32'(idx_ff) + 32'd1;

   always_comb begin
      stat.opcode      = op_ff;
      stat.sk_zero     = (sk_ff == 64'd0);
      stat.bk_zero     = (bk_ff == 64'd0);
      stat.rk_zero     = (rk_ff == 64'd0);
      stat.amt_pos     = !amt_neg_ff && (amt_ff != 63'd0);
      stat.s_empty     = (used_ff == '0);
      stat.s_full      = (used_ff == SCW'(MAX_STATIONS));
      stat.s_end       = (idx_ff == IXW'(used_ff));
      stat.s_eq        = (sid_ff[sx] == sk_ff);
      stat.s_gt        = (sid_ff[sx] > sk_ff);
      stat.found       = found_ff;
      stat.s_last      = (i32 == n_iter);
      stat.i_end       = (idx_ff == IXW'(icnt));
      stat.i_eq        = (mem_id_ff == rk_ff);
      stat.i_gt        = (mem_id_ff > rk_ff);
      stat.ifound      = ifound_ff;
      stat.i_full      = (icnt == ICW'(MAX_ITEMS_PER_STATION));
      stat.add_ovf     = sum64[63];
      stat.rem_short   = (mem_q_ff < amt_ff);
      stat.rem_zero    = (mem_q_ff == amt_ff);
      stat.idx_gt_ipos = (idx_ff > ipos_ff);
      stat.dn_more     = (i32 < c32);
      stat.l_none      = (n_list == 32'd0);
      stat.l_last      = (i32 == n_list);
   end

   always_comb begin
      unique case (cmd.idx_op)
         ksit_pkg::IX_ZERO:   idx_in = '0;
         ksit_pkg::IX_INC:    idx_in = idx_ff + 1'b1;
         ksit_pkg::IX_DEC:    idx_in = idx_ff - 1'b1;
         ksit_pkg::IX_ICOUNT: idx_in = IXW'(icnt);
         default:             idx_in = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.rd_sel)
         ksit_pkg::RD_PREV: ridx = idx_ff - 1'b1;
         ksit_pkg::RD_NEXT: ridx = idx_ff + 1'b1;
         default:           ridx = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         ksit_pkg::WS_UPD: begin
            wid = rk_ff;
            wq  = qupd;
         end
         ksit_pkg::WS_NEW: begin
            wid = rk_ff;
            wq  = amt_ff;
         end
         default: begin
            wid = mem_id_ff;
            wq  = mem_q_ff;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.qsel)
         ksit_pkg::Q_MEM:  qout = mem_q_ff;
         ksit_pkg::Q_UPD:  qout = qupd;
         ksit_pkg::Q_AMT:  qout = amt_ff;
         default:          qout = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         sk_ff      <= req_station_key;
         bk_ff      <= req_body_key;
         fk_ff      <= req_frame_key;
         rk_ff      <= req_resource_key;
         amt_ff     <= req_amount[62:0];
         amt_neg_ff <= req_amount[63];
         maxi_ff    <= req_max_items;
      end
      idx_ff <= idx_in;
      if (cmd.set_pos) begin
         pos_ff   <= idx_ff;
         found_ff <= cmd.found_val;
      end
      if (cmd.set_ifound) begin
         ifound_ff <= cmd.ifound_val;
      end
      if (cmd.set_ipos) begin
         ipos_ff <= idx_ff;
      end
      if (cmd.s_insert) begin
         for (int j = 0; j < SD; j++) begin
            if (IXW'(j) == pos_ff) begin
               sid_ff[j]  <= sk_ff;
               sbd_ff[j]  <= bk_ff;
               sfr_ff[j]  <= fk_ff;
               smap_ff[j] <= used_ff[SW-1:0];
            end else if (j > 0 && IXW'(j) > pos_ff && IXW'(j) <= IXW'(used_ff)) begin
               sid_ff[j]  <= sid_ff[j-1];
               sbd_ff[j]  <= sbd_ff[j-1];
               sfr_ff[j]  <= sfr_ff[j-1];
               smap_ff[j] <= smap_ff[j-1];
            end
         end
      end
      if (cmd.mem_wr) begin
         mid_mem[{slot, idx_ff[IW-1:0]}] <= wid;
         mq_mem[{slot, idx_ff[IW-1:0]}]  <= wq;
      end
      if (cmd.mem_rd) begin
         mem_id_ff <= mid_mem[{slot, ridx[IW-1:0]}];
         mem_q_ff  <= mq_mem[{slot, ridx[IW-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int j = 0; j < SD; j++) begin
            icnt_ff[j] <= '0;
         end
      end else begin
         if (cmd.clear) begin
            used_ff <= '0;
         end else if (cmd.s_insert) begin
            used_ff <= used_ff + 1'b1;
            icnt_ff[used_ff[SW-1:0]] <= '0;
         end
         if (cmd.items_inc) begin
            icnt_ff[slot] <= icnt + 1'b1;
         end else if (cmd.items_dec) begin
            icnt_ff[slot] <= icnt - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_status       <= cmd.rstatus;
         rsp_last         <= cmd.last;
         rsp_item_valid   <= (cmd.kind != ksit_pkg::K_STATUS);
         rsp_out_station  <= '0;
         rsp_out_body     <= '0;
         rsp_out_frame    <= '0;
         rsp_out_resource <= '0;
         rsp_quantity     <= '0;
         if (cmd.kind == ksit_pkg::K_STATION) begin
            rsp_out_station <= sid_ff[sx];
            rsp_out_body    <= sbd_ff[sx];
            rsp_out_frame   <= sfr_ff[sx];
         end else if (cmd.kind == ksit_pkg::K_ITEM) begin
            rsp_out_station  <= sk_ff;
            rsp_out_resource <= (cmd.qsel == ksit_pkg::Q_MEM) ? mem_id_ff : rk_ff;
            rsp_quantity     <= qout;
         end
         unique case (cmd.tot_sel)
            ksit_pkg::T_STATIONS: rsp_total <= 5'(used_ff);
            ksit_pkg::T_ITEMS:    rsp_total <= 5'(icnt);
            default:              rsp_total <= 5'd0;
         endcase
      end
   end

endmodule

// File: rtl/keyed_station_inventory_table.sv
// Top level of the keyed station inventory table: controller plus datapath.
// Depends on ksit_pkg, ksit_ctrl, ksit_dpath and the assertion macro header.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         taken when start is high and busy low
//   result    rsp_valid, rsp_*           one-cycle strobe, cannot be held off
//
// An item passes through decode and, when it names a station, the station scan
// and its verdict, then a read state and a check or write state for each
// inventory entry read or moved (search, shift or list). Reset is synchronous
// and empties both levels at once. The block takes no new item until the last
// result of the current one is registered; results are registered and leave
// in the cycle after they are produced.
`include "keyed_station_inventory_table_defines.svh"

module keyed_station_inventory_table #(
   parameter int MAX_STATIONS          = ksit_pkg::MAX_STATIONS_DEF,
   parameter int MAX_ITEMS_PER_STATION = ksit_pkg::MAX_ITEMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_opcode,
   input  logic [63:0]        req_station_key,
   input  logic [63:0]        req_body_key,
   input  logic [63:0]        req_frame_key,
   input  logic [63:0]        req_resource_key,
   input  logic signed [63:0] req_amount,
   input  logic [4:0]         req_max_items,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [63:0]        rsp_out_station,
   output logic [63:0]        rsp_out_body,
   output logic [63:0]        rsp_out_frame,
   output logic [63:0]        rsp_out_resource,
   output logic [62:0]        rsp_quantity,
   output logic [4:0]         rsp_total,
   output logic               rsp_item_valid,
   output logic               rsp_last
);

   ksit_pkg::ksit_cmd_type  cmd;
   ksit_pkg::ksit_stat_type stat;

   ksit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ksit_dpath #(
      .MAX_STATIONS          (MAX_STATIONS),
      .MAX_ITEMS_PER_STATION (MAX_ITEMS_PER_STATION)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_station_key  (req_station_key),
      .req_body_key     (req_body_key),
      .req_frame_key    (req_frame_key),
      .req_resource_key (req_resource_key),
      .req_amount       (req_amount),
      .req_max_items    (req_max_items),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_station  (rsp_out_station),
      .rsp_out_body     (rsp_out_body),
      .rsp_out_frame    (rsp_out_frame),
      .rsp_out_resource (rsp_out_resource),
      .rsp_quantity     (rsp_quantity),
      .rsp_total        (rsp_total),
      .rsp_item_valid   (rsp_item_valid),
      .rsp_last         (rsp_last)
   );

   `KSIT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy did not rise after an accepted item")
   `KSIT_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_last, !busy, "busy still high after the last result")
   `KSIT_ASSERT_IMP(a_more_busy, clock, reset, rsp_valid && !rsp_last, busy, "busy dropped before the last result")
   `KSIT_ASSERT_IMP(a_entry_ok, clock, reset, rsp_valid && rsp_item_valid, rsp_status == ksit_pkg::ST_OK, "entry result without ok status")

endmodule

// File: dv/tb.sv
// Self-checking testbench of the keyed station inventory table.
// Depends on ksit_pkg and keyed_station_inventory_table; a scoreboard class models the table.
`timescale 1ns / 1ps

typedef struct packed {
   logic [2:0]  status;
   logic [63:0] station;
   logic [63:0] body;
   logic [63:0] frame;
   logic [63:0] resource;
   logic [62:0] quantity;
   logic [4:0]  total;
   logic        item_valid;
   logic        last;
} answer_type;

class inventory_scoreboard;
   answer_type  pending[$];
   int          errors;
   logic [63:0] sta_id[16];
   logic [63:0] sta_body[16];
   logic [63:0] sta_frame[16];
   int          sta_count;
   logic [63:0] res_id[16][16];
   logic [62:0] res_qty[16][16];
   int          res_count[16];

   function new();
      errors = 0;
      sta_count = 0;
      foreach (res_count[i]) res_count[i] = 0;
   endfunction

   function void push(logic [2:0] st, logic [63:0] s, logic [63:0] b, logic [63:0] f,
                      logic [63:0] r, logic [62:0] q, logic [4:0] t, logic v, logic l);
      answer_type a;
      a.status = st; a.station = s; a.body = b; a.frame = f; a.resource = r;
      a.quantity = q; a.total = t; a.item_valid = v; a.last = l;
      pending.push_back(a);
   endfunction

   function void push_status(logic [2:0] st);
      push(st, 0, 0, 0, 0, 0, 0, 0, 1);
   endfunction

   function int find_station(logic [63:0] id);
      for (int i = 0; i < sta_count; i++) if (sta_id[i] == id) return i;
      return -1;
   endfunction

   function void note_item(logic [3:0] op, logic [63:0] sk, logic [63:0] bk,
                           logic [63:0] fk, logic [63:0] rk, logic [63:0] amt,
                           logic [4:0] maxi);
      int si, ii, pos, n;
      logic [63:0] q;
      logic amt_pos;
      amt_pos = (amt != 0) && !amt[63];
      case (op)
         ksit_pkg::OP_CLEAR: begin
            sta_count = 0;
            foreach (res_count[i]) res_count[i] = 0;
            push_status(ksit_pkg::ST_OK);
         end
         ksit_pkg::OP_REG: begin
            if (sk == 0 || bk == 0) push_status(ksit_pkg::ST_INVDATA);
            else if (find_station(sk) >= 0) push_status(ksit_pkg::ST_DUP);
            else if (sta_count >= 16) push_status(ksit_pkg::ST_FULL);
            else begin
               pos = 0;
               while (pos < sta_count && sta_id[pos] < sk) pos++;
               for (int i = sta_count; i > pos; i--) begin
                  sta_id[i] = sta_id[i-1]; sta_body[i] = sta_body[i-1];
                  sta_frame[i] = sta_frame[i-1]; res_count[i] = res_count[i-1];
                  res_id[i] = res_id[i-1]; res_qty[i] = res_qty[i-1];
               end
               sta_id[pos] = sk; sta_body[pos] = bk; sta_frame[pos] = fk;
               res_count[pos] = 0;
               sta_count++;
               push_status(ksit_pkg::ST_OK);
            end
         end
         ksit_pkg::OP_GET: begin
            si = find_station(sk);
            if (si < 0) push_status(ksit_pkg::ST_NOTFOUND);
            else push(ksit_pkg::ST_OK, sta_id[si], sta_body[si], sta_frame[si], 0, 0, 0, 1, 1);
         end
         ksit_pkg::OP_ITER: begin
            if (sta_count == 0) push_status(ksit_pkg::ST_OK);
            else for (int i = 0; i < sta_count; i++)
               push(ksit_pkg::ST_OK, sta_id[i], sta_body[i], sta_frame[i], 0, 0,
                    5'(sta_count), 1, i + 1 == sta_count);
         end
         ksit_pkg::OP_COUNT: push(ksit_pkg::ST_OK, 0, 0, 0, 0, 0, 5'(sta_count), 0, 1);
         ksit_pkg::OP_INV_GET, ksit_pkg::OP_INV_ADD, ksit_pkg::OP_INV_REM: begin
            si = find_station(sk);
            ii = -1;
            if (si >= 0)
               for (int i = 0; i < res_count[si]; i++) if (res_id[si][i] == rk) ii = i;
            if (sk == 0 || rk == 0) push_status(ksit_pkg::ST_INVARG);
            else if (op != ksit_pkg::OP_INV_GET && !amt_pos) push_status(ksit_pkg::ST_INVDATA);
            else if (si < 0) push_status(ksit_pkg::ST_NOTFOUND);
            else if (op == ksit_pkg::OP_INV_GET) begin
               if (ii < 0) push_status(ksit_pkg::ST_NOTFOUND);
               else push(ksit_pkg::ST_OK, sk, 0, 0, rk, res_qty[si][ii], 0, 1, 1);
            end else if (op == ksit_pkg::OP_INV_ADD) begin
               if (ii >= 0) begin
                  q = {1'b0, res_qty[si][ii]};
                  if (q > 64'h7FFF_FFFF_FFFF_FFFF - amt) push_status(ksit_pkg::ST_OVERFLOW);
                  else begin
                     q = q + amt;
                     res_qty[si][ii] = q[62:0];
                     push(ksit_pkg::ST_OK, sk, 0, 0, rk, q[62:0], 0, 1, 1);
                  end
               end else if (res_count[si] >= 16) push_status(ksit_pkg::ST_FULL);
               else begin
                  pos = 0;
                  while (pos < res_count[si] && res_id[si][pos] < rk) pos++;
                  for (int i = res_count[si]; i > pos; i--) begin
                     res_id[si][i] = res_id[si][i-1]; res_qty[si][i] = res_qty[si][i-1];
                  end
                  res_id[si][pos] = rk; res_qty[si][pos] = amt[62:0];
                  res_count[si]++;
                  push(ksit_pkg::ST_OK, sk, 0, 0, rk, amt[62:0], 0, 1, 1);
               end
            end else begin
               if (ii < 0 || {1'b0, res_qty[si][ii]} < amt) push_status(ksit_pkg::ST_INSUFF);
               else begin
                  q = {1'b0, res_qty[si][ii]} - amt;
                  res_qty[si][ii] = q[62:0];
                  if (q == 0) begin
                     for (int i = ii; i + 1 < res_count[si]; i++) begin
                        res_id[si][i] = res_id[si][i+1]; res_qty[si][i] = res_qty[si][i+1];
                     end
                     res_count[si]--;
                  end
                  push(ksit_pkg::ST_OK, sk, 0, 0, rk, q[62:0], 0, 1, 1);
               end
            end
         end
         ksit_pkg::OP_INV_LST: begin
            si = find_station(sk);
            if (sk == 0) push_status(ksit_pkg::ST_INVARG);
            else if (si < 0) push_status(ksit_pkg::ST_NOTFOUND);
            else begin
               n = res_count[si] > maxi ? maxi : res_count[si];
               if (n == 0) push(ksit_pkg::ST_OK, 0, 0, 0, 0, 0, 5'(res_count[si]), 0, 1);
               else for (int i = 0; i < n; i++)
                  push(ksit_pkg::ST_OK, sk, 0, 0, res_id[si][i], res_qty[si][i],
                       5'(res_count[si]), 1, i + 1 == n);
            end
         end
         default: push_status(ksit_pkg::ST_INVARG);
      endcase
   endfunction

   function void check_result(answer_type got);
      answer_type w;
      if (pending.size() == 0) begin
         $error("unexpected result, status %0d", got.status);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
         $error("status expected %0d actual %0d", w.status, got.status); errors++;
      end
      if (got.station !== w.station) begin
         $error("out_station expected %h actual %h", w.station, got.station); errors++;
      end
      if (got.body !== w.body) begin
         $error("out_body expected %h actual %h", w.body, got.body); errors++;
      end
      if (got.frame !== w.frame) begin
         $error("out_frame expected %h actual %h", w.frame, got.frame); errors++;
      end
      if (got.resource !== w.resource) begin
         $error("out_resource expected %h actual %h", w.resource, got.resource); errors++;
      end
      if (got.quantity !== w.quantity) begin
         $error("quantity expected %h actual %h", w.quantity, got.quantity); errors++;
      end
      if (got.total !== w.total) begin
         $error("total expected %0d actual %0d", w.total, got.total); errors++;
      end
      if (got.item_valid !== w.item_valid) begin
         $error("item_valid expected %0d actual %0d", w.item_valid, got.item_valid); errors++;
      end
      if (got.last !== w.last) begin
         $error("last expected %0d actual %0d", w.last, got.last); errors++;
      end
   endfunction
endclass

module tb;
   localparam logic [63:0] QTOP = 64'h7FFF_FFFF_FFFF_FFFF;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [3:0]         req_opcode = 0;
   logic [63:0]        req_station_key = 0;
   logic [63:0]        req_body_key = 0;
   logic [63:0]        req_frame_key = 0;
   logic [63:0]        req_resource_key = 0;
   logic signed [63:0] req_amount = 0;
   logic [4:0]         req_max_items = 0;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [63:0]        rsp_out_station, rsp_out_body, rsp_out_frame, rsp_out_resource;
   logic [62:0]        rsp_quantity;
   logic [4:0]         rsp_total;
   logic               rsp_item_valid, rsp_last;

   inventory_scoreboard board = new();
   int                  cycles = 0;
   bit                  calm = 0;

   keyed_station_inventory_table uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      answer_type got;
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_out_station, rsp_out_body, rsp_out_frame,
                rsp_out_resource, rsp_quantity, rsp_total, rsp_item_valid, rsp_last};
         board.check_result(got);
      end
   end

   // The start line stays high between items unless an idle burst is drawn.
   task automatic send_item(logic [3:0] op, logic [63:0] sk, logic [63:0] bk,
                            logic [63:0] fk, logic [63:0] rk, logic [63:0] amt,
                            logic [4:0] maxi);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op; req_station_key <= sk; req_body_key <= bk;
      req_frame_key <= fk; req_resource_key <= rk; req_amount <= amt;
      req_max_items <= maxi;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(op, sk, bk, fk, rk, amt, maxi);
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 9))
         0: pick_key = 0;
         1: pick_key = '1;
         2: pick_key = {$urandom, $urandom};
         default: pick_key = 64'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic logic [63:0] pick_amount();
      case ($urandom_range(0, 9))
         0: pick_amount = 0;
         1: pick_amount = {1'b1, 31'($urandom), $urandom};
         2: pick_amount = QTOP;
         3: pick_amount = {1'b0, 31'($urandom), $urandom};
         default: pick_amount = 64'($urandom_range(1, 50));
      endcase
   endfunction

   initial begin
      logic [3:0] op;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(ksit_pkg::OP_ITER, 0, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_COUNT, 0, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_REG, 0, 5, 1, 0, 0, 0);
      send_item(ksit_pkg::OP_REG, 5, 0, 1, 0, 0, 0);
      send_item(ksit_pkg::OP_REG, '1, '1, '1, 0, 0, 0);
      send_item(ksit_pkg::OP_REG, 7, 3, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_REG, 7, 4, 2, 0, 0, 0);
      send_item(ksit_pkg::OP_GET, 0, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_GET, 7, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_INV_GET, 0, 0, 0, 1, 0, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, 0, 1, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, 9, 0, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, 9, 64'h8000_0000_0000_0000, 0);
      send_item(ksit_pkg::OP_INV_ADD, 8, 0, 0, 9, 1, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, 9, QTOP, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, 9, 1, 0);
      send_item(ksit_pkg::OP_INV_ADD, 7, 0, 0, '1, 3, 0);
      send_item(ksit_pkg::OP_INV_REM, 7, 0, 0, 2, 1, 0);
      send_item(ksit_pkg::OP_INV_REM, 7, 0, 0, '1, 4, 0);
      send_item(ksit_pkg::OP_INV_REM, 7, 0, 0, '1, 3, 0);
      send_item(ksit_pkg::OP_INV_LST, 7, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_INV_LST, 7, 0, 0, 0, 0, 16);
      send_item(ksit_pkg::OP_INV_LST, 0, 0, 0, 0, 0, 31);
      send_item(4'd15, 0, 0, 0, 0, 0, 0);
      for (int k = 1; k <= 17; k++) begin
         send_item(ksit_pkg::OP_REG, 64'(k * 3), 64'(k), 64'(k), 0, 0, 0);
      end
      for (int k = 1; k <= 17; k++) begin
         send_item(ksit_pkg::OP_INV_ADD, 3, 0, 0, 64'(k), 64'(k), 0);
      end
      send_item(ksit_pkg::OP_ITER, 0, 0, 0, 0, 0, 0);
      send_item(ksit_pkg::OP_INV_LST, 3, 0, 0, 0, 0, 31);
      send_item(ksit_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 120; k++) begin
         if (k > 100) calm = 1;
         case ($urandom_range(0, 19))
            0: op = 4'($urandom_range(9, 15));
            1: op = ksit_pkg::OP_CLEAR;
            2, 3, 4: op = ksit_pkg::OP_REG;
            5: op = ksit_pkg::OP_GET;
            6: op = ksit_pkg::OP_ITER;
            7: op = ksit_pkg::OP_COUNT;
            8, 9: op = ksit_pkg::OP_INV_GET;
            10, 11, 12, 13: op = ksit_pkg::OP_INV_ADD;
            14, 15, 16: op = ksit_pkg::OP_INV_REM;
            default: op = ksit_pkg::OP_INV_LST;
         endcase
         send_item(op, pick_key(), pick_key(), {$urandom, $urandom}, pick_key(),
                   pick_amount(), 5'($urandom));
      end
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
